>>> hw/rtl/aes128_block_encrypt_unit_defines.svh
// assertion macros for the block encrypt unit
`ifndef AES128_BLOCK_ENCRYPT_UNIT_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define AES_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define AES_ASSERT_IMPL(label, clk, rst, ante, cons)
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/aes_pkg.sv
package aes_pkg;

   localparam int ROUNDS_DEFAULT = 10;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_OUT
   } aes_state_type;

   typedef enum logic {
      CMD_LOAD    = 1'b0,
      CMD_ENCRYPT = 1'b1
   } aes_cmd_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic round_step;
      logic last_round;
   } aes_ctrl_type;

   // forward s-box
   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
      };
      return t[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

endpackage

>>> hw/rtl/aes_stream_if.sv
interface aes_stream_if #(parameter int WIDTH = 8);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/aes128_block_encrypt_unit.sv
// AES-128 ECB encryption with an externally loaded key schedule. A load beat
// (command 0) writes one 32-bit schedule word and gives no response. An
// encrypt beat runs on the single round unit (the initial key addition and
// ten rounds, one per cycle, each reading one round key row from the schedule
// store) and then one beat is held on the response channel until taken; a new
// beat is accepted from the cycle after the response has gone, so a new block
// is not taken while the last one is still in flight.
// Schedule words must be loaded before they are used.
`include "aes128_block_encrypt_unit_defines.svh"
module aes128_block_encrypt_unit
   import aes_pkg::*;
#(
   parameter int ROUNDS = ROUNDS_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   aes_stream_if.sink   req,
   aes_stream_if.source rsp
);
   localparam int RW = $clog2(ROUNDS + 1);

   logic          enc_ready, enc_valid, key_write;
   logic          resp_valid;
   logic [RW-1:0] round_num;
   aes_ctrl_type  ctrl;
   logic [127:0]  cipher;
   logic          last_q;

   // req payload: command, key_index, key_word, block_high, block_low, last_block
   assign enc_valid = req.valid && (req.data[167] == CMD_ENCRYPT);
   assign key_write = req.valid && req.ready && (req.data[167] == CMD_LOAD);
   assign req.ready = enc_ready;

   aes_ctrl #(.ROUNDS(ROUNDS), .RW(RW)) u_ctrl (
      .clock(clock), .reset(reset), .enc_valid(enc_valid), .enc_ready(enc_ready),
      .rsp_valid(resp_valid), .rsp_ready(rsp.ready), .round_num(round_num), .ctrl(ctrl)
   );

   aes_datapath #(.ROUNDS(ROUNDS), .RW(RW)) u_dp (
      .clock(clock), .key_write(key_write), .key_index(req.data[166:161]),
      .key_word(req.data[160:129]), .block_in(req.data[128:1]), .last_in(req.data[0]),
      .round_num(round_num), .ctrl(ctrl), .block_out(cipher), .last_out(last_q)
   );

   assign rsp.valid = resp_valid;
   assign rsp.data  = {cipher, last_q};

   `AES_ASSERT_NEXT(a_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid)
   `AES_ASSERT_IMPL(a_busy, clock, reset, rsp.valid, !req.ready)
endmodule

>>> hw/rtl/aes_ctrl.sv
module aes_ctrl
   import aes_pkg::*;
#(
   parameter int ROUNDS = ROUNDS_DEFAULT,
   parameter int RW = $clog2(ROUNDS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               enc_valid,
   output logic               enc_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [RW-1:0]      round_num,
   output aes_ctrl_type       ctrl
);
   aes_state_type state_ff, state_in;
   logic [RW-1:0] round_ff, round_in;

   // next state
   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      case (state_ff)
         ST_IDLE: begin
            if (enc_valid) begin
               state_in = ST_ROUND;
               round_in = RW'(1);
            end
         end
         ST_ROUND: begin
            round_in = round_ff + RW'(1);
            if (round_ff == RW'(ROUNDS)) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs; round_num selects the key row needed at the next step
   always_comb begin
      enc_ready       = 1'b0;
      rsp_valid       = 1'b0;
      ctrl.start      = 1'b0;
      ctrl.round_step = 1'b0;
      ctrl.last_round = 1'b0;
      round_num       = '0;
      case (state_ff)
         ST_IDLE: begin
            enc_ready  = 1'b1;
            ctrl.start = enc_valid;
            round_num  = enc_valid ? RW'(1) : '0;
         end
         ST_ROUND: begin
            ctrl.round_step = 1'b1;
            ctrl.last_round = (round_ff == RW'(ROUNDS));
            round_num       = (round_ff == RW'(ROUNDS)) ? '0 : round_ff + RW'(1);
         end
         ST_OUT: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
      end
   end
endmodule

>>> hw/rtl/aes_datapath.sv
module aes_datapath
   import aes_pkg::*;
#(
   parameter int ROUNDS = ROUNDS_DEFAULT,
   parameter int RW = $clog2(ROUNDS + 1),
   parameter int KW = 4 * (ROUNDS + 1)
) (
   input  logic           clock,
   input  logic           key_write,
   input  logic [5:0]     key_index,
   input  logic [31:0]    key_word,
   input  logic [127:0]   block_in,
   input  logic           last_in,
   input  logic [RW-1:0]  round_num,
   input  aes_ctrl_type   ctrl,
   output logic [127:0]   block_out,
   output logic           last_out
);
   logic [127:0] key_mem [ROUNDS+1];
   logic [127:0] rk_ff;
   logic [127:0] fwd_mask, fwd_word;
   logic [RW-1:0] row_sel;
   logic [1:0] col_sel;
   logic key_hit;
   logic [127:0] state_ff, state_in, ss, mc, rnd;
   logic last_ff;

   // schedule store: one 128-bit row per round key, word lane per write
   assign row_sel = RW'(key_index >> 2);
   assign col_sel = key_index[1:0];
   assign key_hit = key_write && (key_index < 6'(KW));

   // word written this cycle into the row being read is passed straight on
   always_comb begin
      fwd_mask = '0;
      fwd_word = '0;
      if (key_hit && (row_sel == round_num)) begin
         fwd_mask[127 - 32*col_sel -: 32] = '1;
         fwd_word[127 - 32*col_sel -: 32] = key_word;
      end
   end

   // round key for the coming step is registered ahead of that step
   always_ff @(posedge clock) begin
      if (key_hit) begin
         key_mem[row_sel][127 - 32*col_sel -: 32] <= key_word;
      end
      rk_ff <= (key_mem[round_num] & ~fwd_mask) | fwd_word;
   end

   // sub bytes, shift rows and mix columns (not in the last round); byte 4c+r at bits 127-8(4c+r)
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            ss[127-8*(4*c+r) -: 8] = sbox(state_ff[127-8*(4*((c+r)&3)+r) -: 8]);
         end
      end
      for (int c = 0; c < 4; c++) begin
         logic [7:0] a0, a1, a2, a3;
         a0 = ss[127-32*c -: 8];
         a1 = ss[119-32*c -: 8];
         a2 = ss[111-32*c -: 8];
         a3 = ss[103-32*c -: 8];
         mc[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         mc[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         mc[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         mc[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      rnd = ctrl.last_round ? ss : mc;
   end

   // load the block or apply one round
   always_comb begin
      state_in = state_ff;
      if (ctrl.start) state_in = block_in;
      else if (ctrl.round_step) state_in = rnd;
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in ^ ((ctrl.start || ctrl.round_step) ? rk_ff : 128'b0);
      if (ctrl.start) last_ff <= last_in;
   end

   assign block_out = state_ff;
   assign last_out  = last_ff;
endmodule
